// ===== src/tccw_pkg.sv =====
// Shared types, codes and sizes of the text console cell writer.
package tccw_pkg;

	localparam int MAX_COLS    = 240;
	localparam int MAX_ROWS    = 67;
	localparam int TAB_STOP    = 4;
	localparam int MAX_RESULTS = 5;

	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W  = $clog2(MAX_COLS + 1);
	localparam int ROW_W  = $clog2(MAX_ROWS + 1);
	localparam int TAB_W  = $clog2(TAB_STOP + 1);
	localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0]  RST_NUM_COLS = 8'd80;
	localparam logic [6:0]  RST_NUM_ROWS = 7'd25;
	localparam logic [31:0] RST_FG       = 32'h00FF_FFFF;
	localparam logic [31:0] RST_BG       = 32'h0000_0000;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_SPACE = 8'd32;

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_SET   = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		EV_DRAW   = 2'd0,
		EV_SCROLL = 2'd1,
		EV_CLEAR  = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		REG_NUM_COLS = 2'd0,
		REG_NUM_ROWS = 2'd1,
		REG_FG_COLOR = 2'd2,
		REG_BG_COLOR = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_SCROLL_COPY,
		ST_SCROLL_BLANK,
		ST_SCROLL_EMIT,
		ST_CLEAR,
		ST_CLEAR_EMIT
	} state_t;

	typedef struct packed {
		logic [31:0] bg;
		logic [31:0] fg;
		logic [7:0]  ch;
	} cell_t;

endpackage

// ===== src/text_console_cell_writer.sv =====
// Text console cell store with cursor, scroll and clear; draws, scrolls and clears
// are reported as events. A plain character is accepted in idle and its draw word is
// registered from the put state once the output is free; a tab writes its spaces in turn.
// A scroll walks the store, about (rows-1)*cols reads and writes plus cols blanks,
// through the single write port; a clear writes rows*cols cells. Input is taken only in idle.
// After reset a clearing pass over MAX_ROWS*MAX_COLS cells runs with s_tready low.
module text_console_cell_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], cursor_col[15:8], cursor_row[22:16]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // cell_col, cell_row, cell_char, cell_fg, cell_bg
	output logic [1:0]  m_tuser,   // event_res[1:0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int COL_W  = tccw_pkg::COL_W;
	localparam int ROW_W  = tccw_pkg::ROW_W;
	localparam int ADDR_W = tccw_pkg::ADDR_W;
	localparam int TAB_W  = tccw_pkg::TAB_W;
	localparam int CNT_W  = tccw_pkg::CNT_W;

	// Configuration
	logic [7:0]  num_cols_q;
	logic [6:0]  num_rows_q;
	logic [31:0] fg_color_q;
	logic [31:0] bg_color_q;

	// Sequencer state
	tccw_pkg::state_t state_q, state_d;
	logic [COL_W-1:0]  cur_col_q, cur_col_d;
	logic [ROW_W-1:0]  cur_row_q, cur_row_d;
	logic [7:0]        op_char_q, op_char_d;
	logic [TAB_W-1:0]  tab_left_q, tab_left_d;
	logic [CNT_W-1:0]  n_q, n_d;
	logic              scroll_last_q, scroll_last_d;
	logic [COL_W-1:0]  wcol_q, wcol_d;
	logic [ROW_W-1:0]  wrow_q, wrow_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic [ADDR_W-1:0] init_addr_q, init_addr_d;
	logic              cp_valid_s1, cp_valid_d;
	logic [ADDR_W-1:0] cp_addr_s1, cp_addr_d;

	// Cell store
	tccw_pkg::cell_t   cell_mem [tccw_pkg::DEPTH];
	tccw_pkg::cell_t   rd_data_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	tccw_pkg::cell_t   mem_wdata;

	// Output register
	logic        m_tvalid_q;
	logic [1:0]  ev_q;
	logic [7:0]  col_q;
	logic [6:0]  row_q;
	logic [7:0]  char_q;
	logic [31:0] fg_q, bg_q;
	logic        last_q;

	logic        emit, emit_last;
	logic [1:0]  emit_ev;
	logic [7:0]  emit_col, emit_char;
	logic [6:0]  emit_row;
	logic [31:0] emit_fg, emit_bg;

	// Helpers
	logic [COL_W-1:0] cols;
	logic [ROW_W-1:0] rows;
	logic             s_fire, out_free;
	logic             is_nl, is_bs, is_tab;
	logic             at_bottom, past_end, draw_last;
	logic [COL_W:0]   col_nx;
	logic [CNT_W+1:0] res_sum;
	logic [COL_W-1:0] put_col;
	logic [ROW_W-1:0] put_row;
	logic [7:0]       in_char, in_col;
	logic [6:0]       in_row;
	logic [7:0]       wr_char;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(r * tccw_pkg::MAX_COLS) + ADDR_W'(c);
	endfunction

	assign in_char = s_tdata[7:0];
	assign in_col  = s_tdata[15:8];
	assign in_row  = s_tdata[22:16];

	always_comb begin
		if (num_cols_q == 8'd0) begin
			cols = COL_W'(1);
		end else if (9'(num_cols_q) > 9'(tccw_pkg::MAX_COLS)) begin
			cols = COL_W'(tccw_pkg::MAX_COLS);
		end else begin
			cols = COL_W'(num_cols_q);
		end
		if (num_rows_q == 7'd0) begin
			rows = ROW_W'(1);
		end else if (8'(num_rows_q) > 8'(tccw_pkg::MAX_ROWS)) begin
			rows = ROW_W'(tccw_pkg::MAX_ROWS);
		end else begin
			rows = ROW_W'(num_rows_q);
		end
	end

	assign s_tready  = (state_q == tccw_pkg::ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign is_nl  = (op_char_q == tccw_pkg::CH_NL);
	assign is_bs  = (op_char_q == tccw_pkg::CH_BS);
	assign is_tab = (op_char_q == tccw_pkg::CH_TAB);
	assign wr_char = is_tab ? tccw_pkg::CH_SPACE : op_char_q;

	assign at_bottom = ((ROW_W + 1)'(cur_row_q) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(rows);
	assign past_end  = cur_col_q >= cols;

	// A tab space is the last word once the spaces run out or the next one, with any
	// scroll it needs, would no longer fit in the result limit.
	assign col_nx  = (COL_W + 1)'(cur_col_q) + (COL_W + 1)'(1);
	assign res_sum = (CNT_W + 2)'(n_q) + (CNT_W + 2)'(1)
		+ (((col_nx >= (COL_W + 1)'(cols)) && at_bottom) ? (CNT_W + 2)'(2) : (CNT_W + 2)'(1));
	assign draw_last = !is_tab || (tab_left_q == TAB_W'(1))
		|| (res_sum > (CNT_W + 2)'(tccw_pkg::MAX_RESULTS));

	// Cursor as taken before a put: past the last column clamps to the past-last place, past the last row to the last row.
	always_comb begin
		put_col = (cur_col_q > cols) ? cols : cur_col_q;
		put_row = (cur_row_q >= rows) ? rows - ROW_W'(1) : cur_row_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tccw_pkg::ST_INIT: begin
				if (init_addr_q == ADDR_W'(tccw_pkg::DEPTH - 1)) state_d = tccw_pkg::ST_IDLE;
			end
			tccw_pkg::ST_IDLE: begin
				if (s_fire) begin
					unique case (tccw_pkg::action_t'(s_tuser))
						tccw_pkg::ACT_PUT:   state_d = tccw_pkg::ST_PUT;
						tccw_pkg::ACT_CLEAR: state_d = tccw_pkg::ST_CLEAR;
						default:             state_d = tccw_pkg::ST_IDLE;
					endcase
				end
			end
			tccw_pkg::ST_PUT: begin
				if (is_nl) begin
					state_d = at_bottom ? tccw_pkg::ST_SCROLL_COPY : tccw_pkg::ST_IDLE;
				end else if (is_bs) begin
					if (cur_col_q == '0 || out_free) state_d = tccw_pkg::ST_IDLE;
				end else if (past_end) begin
					if (at_bottom) state_d = tccw_pkg::ST_SCROLL_COPY;
				end else if (out_free && draw_last) begin
					state_d = tccw_pkg::ST_IDLE;
				end
			end
			tccw_pkg::ST_SCROLL_COPY: begin
				if ((ROW_W + 1)'(wrow_q) + (ROW_W + 1)'(1) >= (ROW_W + 1)'(rows))
					state_d = tccw_pkg::ST_SCROLL_BLANK;
			end
			tccw_pkg::ST_SCROLL_BLANK: begin
				if (!cp_valid_s1 && wcol_q == cols - COL_W'(1))
					state_d = tccw_pkg::ST_SCROLL_EMIT;
			end
			tccw_pkg::ST_SCROLL_EMIT: begin
				if (out_free) state_d = scroll_last_q ? tccw_pkg::ST_IDLE : tccw_pkg::ST_PUT;
			end
			tccw_pkg::ST_CLEAR: begin
				if (wcol_q == cols - COL_W'(1) && wrow_q == rows - ROW_W'(1))
					state_d = tccw_pkg::ST_CLEAR_EMIT;
			end
			tccw_pkg::ST_CLEAR_EMIT: begin
				if (out_free) state_d = tccw_pkg::ST_IDLE;
			end
			default: state_d = tccw_pkg::ST_IDLE;
		endcase
	end

	// Datapath, store port and result words
	always_comb begin
		cur_col_d     = cur_col_q;
		cur_row_d     = cur_row_q;
		op_char_d     = op_char_q;
		tab_left_d    = tab_left_q;
		n_d           = n_q;
		scroll_last_d = scroll_last_q;
		wcol_d        = wcol_q;
		wrow_d        = wrow_q;
		base_d        = base_q;
		init_addr_d   = init_addr_q;
		cp_valid_d    = 1'b0;
		cp_addr_d     = cp_addr_s1;
		mem_we        = 1'b0;
		mem_waddr     = cp_addr_s1;
		mem_wdata     = rd_data_q;
		mem_re        = 1'b0;
		mem_raddr     = base_q + ADDR_W'(tccw_pkg::MAX_COLS) + ADDR_W'(wcol_q);
		emit          = 1'b0;
		emit_ev       = tccw_pkg::EV_DRAW;
		emit_col      = 8'd0;
		emit_row      = 7'd0;
		emit_char     = 8'd0;
		emit_fg       = 32'd0;
		emit_bg       = 32'd0;
		emit_last     = 1'b0;

		// The copy read in the cycle before lands one row up.
		if (cp_valid_s1) mem_we = 1'b1;

		unique case (state_q)
			tccw_pkg::ST_INIT: begin
				mem_we      = 1'b1;
				mem_waddr   = init_addr_q;
				mem_wdata   = '{bg: tccw_pkg::RST_BG, fg: tccw_pkg::RST_FG,
					ch: tccw_pkg::CH_SPACE};
				init_addr_d = init_addr_q + ADDR_W'(1);
			end
			tccw_pkg::ST_IDLE: begin
				if (s_fire) begin
					unique case (tccw_pkg::action_t'(s_tuser))
						tccw_pkg::ACT_SET: begin
							if (9'(in_col) < 9'(cols)) cur_col_d = COL_W'(in_col);
							if (8'(in_row) < 8'(rows)) cur_row_d = ROW_W'(in_row);
						end
						tccw_pkg::ACT_CLEAR: begin
							cur_col_d = '0;
							cur_row_d = '0;
							wcol_d    = '0;
							wrow_d    = '0;
							base_d    = '0;
						end
						tccw_pkg::ACT_PUT: begin
							cur_col_d  = put_col;
							cur_row_d  = put_row;
							op_char_d  = in_char;
							n_d        = '0;
							tab_left_d = TAB_W'(tccw_pkg::TAB_STOP)
								- TAB_W'(put_col % tccw_pkg::TAB_STOP);
						end
						tccw_pkg::ACT_NONE: begin
						end
						default: begin
						end
					endcase
				end
			end
			tccw_pkg::ST_PUT: begin
				if (is_nl) begin
					cur_col_d = '0;
					if (at_bottom) begin
						scroll_last_d = 1'b1;
						wcol_d = '0;
						wrow_d = '0;
						base_d = '0;
					end else begin
						cur_row_d = cur_row_q + ROW_W'(1);
					end
				end else if (is_bs) begin
					if (cur_col_q != '0 && out_free) begin
						cur_col_d = cur_col_q - COL_W'(1);
						mem_we    = 1'b1;
						mem_waddr = cell_addr(cur_row_q, cur_col_q - COL_W'(1));
						mem_wdata = '{bg: bg_color_q, fg: fg_color_q, ch: tccw_pkg::CH_SPACE};
						emit      = 1'b1;
						emit_col  = 8'(cur_col_q - COL_W'(1));
						emit_row  = 7'(cur_row_q);
						emit_char = tccw_pkg::CH_SPACE;
						emit_fg   = fg_color_q;
						emit_bg   = bg_color_q;
						emit_last = 1'b1;
					end
				end else if (past_end) begin
					cur_col_d = '0;
					if (at_bottom) begin
						scroll_last_d = 1'b0;
						wcol_d = '0;
						wrow_d = '0;
						base_d = '0;
					end else begin
						cur_row_d = cur_row_q + ROW_W'(1);
					end
				end else if (out_free) begin
					mem_we     = 1'b1;
					mem_waddr  = cell_addr(cur_row_q, cur_col_q);
					mem_wdata  = '{bg: bg_color_q, fg: fg_color_q, ch: wr_char};
					emit       = 1'b1;
					emit_col   = 8'(cur_col_q);
					emit_row   = 7'(cur_row_q);
					emit_char  = wr_char;
					emit_fg    = fg_color_q;
					emit_bg    = bg_color_q;
					emit_last  = draw_last;
					cur_col_d  = cur_col_q + COL_W'(1);
					n_d        = n_q + CNT_W'(1);
					tab_left_d = tab_left_q - TAB_W'(1);
				end
			end
			tccw_pkg::ST_SCROLL_COPY: begin
				if ((ROW_W + 1)'(wrow_q) + (ROW_W + 1)'(1) < (ROW_W + 1)'(rows)) begin
					mem_re     = 1'b1;
					cp_valid_d = 1'b1;
					cp_addr_d  = base_q + ADDR_W'(wcol_q);
					if (wcol_q == cols - COL_W'(1)) begin
						wcol_d = '0;
						wrow_d = wrow_q + ROW_W'(1);
						base_d = base_q + ADDR_W'(tccw_pkg::MAX_COLS);
					end else begin
						wcol_d = wcol_q + COL_W'(1);
					end
				end
			end
			tccw_pkg::ST_SCROLL_BLANK: begin
				if (!cp_valid_s1) begin
					mem_we    = 1'b1;
					mem_waddr = base_q + ADDR_W'(wcol_q);
					mem_wdata = '{bg: bg_color_q, fg: fg_color_q, ch: tccw_pkg::CH_SPACE};
					wcol_d    = wcol_q + COL_W'(1);
				end
			end
			tccw_pkg::ST_SCROLL_EMIT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_ev   = tccw_pkg::EV_SCROLL;
					emit_last = scroll_last_q;
					n_d       = n_q + CNT_W'(1);
				end
			end
			tccw_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = base_q + ADDR_W'(wcol_q);
				mem_wdata = '{bg: bg_color_q, fg: fg_color_q, ch: tccw_pkg::CH_SPACE};
				if (wcol_q == cols - COL_W'(1)) begin
					wcol_d = '0;
					wrow_d = wrow_q + ROW_W'(1);
					base_d = base_q + ADDR_W'(tccw_pkg::MAX_COLS);
				end else begin
					wcol_d = wcol_q + COL_W'(1);
				end
			end
			tccw_pkg::ST_CLEAR_EMIT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_ev   = tccw_pkg::EV_CLEAR;
					emit_last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tccw_pkg::ST_INIT;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			tab_left_q    <= '0;
			n_q           <= '0;
			scroll_last_q <= 1'b0;
			wcol_q        <= '0;
			wrow_q        <= '0;
			base_q        <= '0;
			init_addr_q   <= '0;
			cp_valid_s1   <= 1'b0;
			m_tvalid_q    <= 1'b0;
			num_cols_q    <= tccw_pkg::RST_NUM_COLS;
			num_rows_q    <= tccw_pkg::RST_NUM_ROWS;
			fg_color_q    <= tccw_pkg::RST_FG;
			bg_color_q    <= tccw_pkg::RST_BG;
		end else begin
			state_q       <= state_d;
			cur_col_q     <= cur_col_d;
			cur_row_q     <= cur_row_d;
			tab_left_q    <= tab_left_d;
			n_q           <= n_d;
			scroll_last_q <= scroll_last_d;
			wcol_q        <= wcol_d;
			wrow_q        <= wrow_d;
			base_q        <= base_d;
			init_addr_q   <= init_addr_d;
			cp_valid_s1   <= cp_valid_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (tccw_pkg::reg_index_t'(cfg_index))
					tccw_pkg::REG_NUM_COLS: num_cols_q <= cfg_data[7:0];
					tccw_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data[6:0];
					tccw_pkg::REG_FG_COLOR: fg_color_q <= cfg_data;
					tccw_pkg::REG_BG_COLOR: bg_color_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		op_char_q  <= op_char_d;
		cp_addr_s1 <= cp_addr_d;
		if (emit) begin
			ev_q   <= emit_ev;
			col_q  <= emit_col;
			row_q  <= emit_row;
			char_q <= emit_char;
			fg_q   <= emit_fg;
			bg_q   <= emit_bg;
			last_q <= emit_last;
		end
	end

	// Cell store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_q <= cell_mem[mem_raddr];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, bg_q, fg_q, char_q, row_q, col_q};
	assign m_tuser  = ev_q;
	assign m_tlast  = last_q;

endmodule

// ===== dv/tccw_event_checker.sv =====
// Checker for the console cell writer: tracks cursor and registers, predicts and compares event words.
`timescale 1ns / 100ps

module tccw_event_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], cursor_col[15:8], cursor_row[22:16]
	input  logic [1:0]  s_tuser,   // action[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,   // cell_col[7:0], cell_row[14:8], cell_char[22:15],
	                               // cell_fg[54:23], cell_bg[86:55]
	input  logic [1:0]  m_tuser,   // event_res[1:0]
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatch_count,
	output int          events_awaited,
	output int          events_seen
);

	typedef struct {
		tccw_pkg::event_t ev;
		logic [7:0]       col;
		logic [6:0]       row;
		logic [7:0]       ch;
		logic [31:0]      fg;
		logic [31:0]      bg;
		logic             last;
	} console_event_t;

	console_event_t awaited_events[$];
	console_event_t item_events[$];

	// The cell store never shows up in an event word (draws carry the current colours),
	// so only the registers and the cursor are tracked here.
	logic [7:0]  num_cols;
	logic [6:0]  num_rows;
	logic [31:0] fg_color;
	logic [31:0] bg_color;
	int          cur_col;
	int          cur_row;

	function automatic void add_event(tccw_pkg::event_t ev, int col, int row, int ch,
	                                  logic [31:0] fg, logic [31:0] bg);
		console_event_t e;
		if (item_events.size() >= tccw_pkg::MAX_RESULTS) return;
		e.ev   = ev;
		e.col  = col[7:0];
		e.row  = row[6:0];
		e.ch   = ch[7:0];
		e.fg   = fg;
		e.bg   = bg;
		e.last = 1'b0;
		item_events.push_back(e);
	endfunction

	function automatic void next_line(int rows);
		cur_col = 0;
		cur_row++;
		if (cur_row >= rows) begin
			cur_row = rows - 1;
			add_event(tccw_pkg::EV_SCROLL, 0, 0, 0, '0, '0);
		end
	endfunction

	function automatic void put_cell(int ch, int cols, int rows);
		if (cur_col >= cols) next_line(rows);
		add_event(tccw_pkg::EV_DRAW, cur_col, cur_row, ch, fg_color, bg_color);
		cur_col++;
	endfunction

	function automatic void predict_console_events(tccw_pkg::action_t act, logic [7:0] ch,
	                                               logic [7:0] col, logic [6:0] row);
		int cols;
		int rows;
		int spaces;
		int need;
		cols = (num_cols == 8'd0) ? 1
			: (num_cols > tccw_pkg::MAX_COLS) ? tccw_pkg::MAX_COLS : int'(num_cols);
		rows = (num_rows == 7'd0) ? 1
			: (num_rows > tccw_pkg::MAX_ROWS) ? tccw_pkg::MAX_ROWS : int'(num_rows);
		item_events.delete();
		case (act)
		tccw_pkg::ACT_SET: begin
			if (int'(col) < cols) cur_col = int'(col);
			if (int'(row) < rows) cur_row = int'(row);
		end
		tccw_pkg::ACT_CLEAR: begin
			cur_col = 0;
			cur_row = 0;
			add_event(tccw_pkg::EV_CLEAR, 0, 0, 0, '0, '0);
		end
		tccw_pkg::ACT_PUT: begin
			// A cursor left off screen by a register change is pulled back first.
			if (cur_col > cols) cur_col = cols;
			if (cur_row >= rows) cur_row = rows - 1;
			if (ch == tccw_pkg::CH_NL) begin
				next_line(rows);
			end else if (ch == tccw_pkg::CH_BS) begin
				if (cur_col > 0) begin
					cur_col--;
					add_event(tccw_pkg::EV_DRAW, cur_col, cur_row, int'(tccw_pkg::CH_SPACE),
					          fg_color, bg_color);
				end
			end else if (ch == tccw_pkg::CH_TAB) begin
				spaces = tccw_pkg::TAB_STOP - (cur_col % tccw_pkg::TAB_STOP);
				for (int i = 0; i < spaces; i++) begin
					// A space that needs a scroll first costs two words.
					need = (cur_col >= cols && cur_row + 1 >= rows) ? 2 : 1;
					if (item_events.size() + need > tccw_pkg::MAX_RESULTS) break;
					put_cell(int'(tccw_pkg::CH_SPACE), cols, rows);
				end
			end else begin
				put_cell(int'(ch), cols, rows);
			end
		end
		default: ;
		endcase
		foreach (item_events[i]) begin
			item_events[i].last = (i == item_events.size() - 1);
			awaited_events.push_back(item_events[i]);
		end
	endfunction

	function automatic string event_text(console_event_t e);
		return $sformatf("ev=%0d col=%0d row=%0d ch=%02h fg=%08h bg=%08h last=%0b",
		                 e.ev, e.col, e.row, e.ch, e.fg, e.bg, e.last);
	endfunction

	function automatic void report_mismatch(string what, string got, string want);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t ns: %s: got %s, expected %s", $realtime, what, got, want);
	endfunction

	function automatic void check_event_word();
		console_event_t got;
		console_event_t want;
		got.ev   = tccw_pkg::event_t'(m_tuser);
		got.col  = m_tdata[7:0];
		got.row  = m_tdata[14:8];
		got.ch   = m_tdata[22:15];
		got.fg   = m_tdata[54:23];
		got.bg   = m_tdata[86:55];
		got.last = m_tlast;
		events_seen++;
		if (awaited_events.size() == 0) begin
			report_mismatch("unexpected word", event_text(got), "nothing");
		end else begin
			want = awaited_events.pop_front();
			if (got.ev !== want.ev || got.col !== want.col || got.row !== want.row ||
			    got.ch !== want.ch || got.fg !== want.fg || got.bg !== want.bg ||
			    got.last !== want.last)
				report_mismatch("word mismatch", event_text(got), event_text(want));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols = tccw_pkg::RST_NUM_COLS;
			num_rows = tccw_pkg::RST_NUM_ROWS;
			fg_color = tccw_pkg::RST_FG;
			bg_color = tccw_pkg::RST_BG;
			cur_col  = 0;
			cur_row  = 0;
			awaited_events.delete();
			events_awaited = 0;
		end else begin
			if (m_tvalid === 1'b1 && m_tready === 1'b1) check_event_word();
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
				case (tccw_pkg::reg_index_t'(cfg_index))
				tccw_pkg::REG_NUM_COLS: num_cols = cfg_data[7:0];
				tccw_pkg::REG_NUM_ROWS: num_rows = cfg_data[6:0];
				tccw_pkg::REG_FG_COLOR: fg_color = cfg_data;
				tccw_pkg::REG_BG_COLOR: bg_color = cfg_data;
				default: ;
				endcase
			end
			if (s_tvalid === 1'b1 && s_tready === 1'b1)
				predict_console_events(tccw_pkg::action_t'(s_tuser), s_tdata[7:0],
				                       s_tdata[15:8], s_tdata[22:16]);
			events_awaited = awaited_events.size();
		end
	end

endmodule

// ===== dv/tb_text_console_cell_writer.sv =====
// Testbench top for the console cell writer: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_text_console_cell_writer;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // char_code[7:0], cursor_col[15:8], cursor_row[22:16]
	logic [1:0]  s_tuser;   // action[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;   // cell_col[7:0], cell_row[14:8], cell_char[22:15],
	                        // cell_fg[54:23], cell_bg[86:55]
	logic [1:0]  m_tuser;   // event_res[1:0]
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int mismatch_count;
	int events_awaited;
	int events_seen;

	bit sink_hold;
	bit sink_eager;
	bit src_eager;
	int items_sent;
	int settings_used;
	int scr_cols;
	int scr_rows;

	text_console_cell_writer DUT (.*);

	tccw_event_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A scroll or clear on the largest screen walks about 16k cells; the limit allows every
	// item sent on a large screen two of those under the longest stalls, several times over.
	initial begin
		#200_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = sink_eager ? 0 : $urandom_range(0, 15);
			if (stall > 0 || sink_hold) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
				while (sink_hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1 && !sink_hold);
		end
	end

	task automatic hold_results(input int cycles);
		@(negedge clk);
		sink_hold <= 1'b1;
		repeat (cycles) @(negedge clk);
		sink_hold <= 1'b0;
	endtask

	task automatic send_item(input tccw_pkg::action_t act, input logic [7:0] ch,
	                         input logic [7:0] col, input logic [6:0] row);
		int gap;
		gap = src_eager ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {1'b0, row, col, ch};
		do @(posedge clk); while (s_tready !== 1'b1);
		items_sent++;
	endtask

	task automatic put_char(input logic [7:0] ch);
		send_item(tccw_pkg::ACT_PUT, ch, 8'd0, 7'd0);
	endtask

	task automatic move_cursor(input logic [7:0] col, input logic [6:0] row);
		send_item(tccw_pkg::ACT_SET, 8'd0, col, row);
	endtask

	// Stops offering words and waits until every predicted event word has arrived.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (events_awaited == 0);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(input tccw_pkg::reg_index_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_screen(input logic [7:0] cols, input logic [6:0] rows,
	                          input logic [31:0] fg, input logic [31:0] bg);
		logic [31:0] noise;
		noise = $urandom();
		write_reg(tccw_pkg::REG_NUM_COLS, {noise[31:8], cols});
		write_reg(tccw_pkg::REG_NUM_ROWS, {noise[31:7], rows});
		write_reg(tccw_pkg::REG_FG_COLOR, fg);
		write_reg(tccw_pkg::REG_BG_COLOR, bg);
		scr_cols = (cols == 8'd0) ? 1
			: (cols > tccw_pkg::MAX_COLS) ? tccw_pkg::MAX_COLS : int'(cols);
		scr_rows = (rows == 7'd0) ? 1
			: (rows > tccw_pkg::MAX_ROWS) ? tccw_pkg::MAX_ROWS : int'(rows);
		settings_used++;
	endtask

	task automatic send_random();
		int                 pick;
		tccw_pkg::action_t  act;
		logic [7:0]         ch;
		logic [7:0]         col;
		logic [6:0]         row;
		pick = $urandom_range(0, 99);
		act  = tccw_pkg::ACT_PUT;
		ch   = 8'($urandom_range(0, 255));
		col  = 8'($urandom_range(0, 255));
		row  = 7'($urandom_range(0, 127));
		if (pick < 45) begin
			act = tccw_pkg::ACT_PUT;
		end else if (pick < 55) begin
			ch = tccw_pkg::CH_NL;
		end else if (pick < 63) begin
			ch = tccw_pkg::CH_BS;
		end else if (pick < 73) begin
			ch = tccw_pkg::CH_TAB;
		end else if (pick < 89) begin
			act = tccw_pkg::ACT_SET;
			// Mostly stay on screen, often on the right edge and the bottom row, to provoke wraps and scrolls.
			if ($urandom_range(0, 3) != 0) begin
				col = 8'($urandom_range(0, 1) ? scr_cols - 1 : $urandom_range(0, scr_cols - 1));
				row = 7'($urandom_range(0, 1) ? scr_rows - 1 : $urandom_range(0, scr_rows - 1));
			end
		end else if (pick < 92) begin
			act = tccw_pkg::ACT_CLEAR;
		end else if (pick < 95) begin
			act = tccw_pkg::ACT_NONE;
		end
		send_item(act, ch, col, row);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 12 == 0) begin
				src_eager  = ($urandom_range(0, 3) == 0);
				sink_eager = ($urandom_range(0, 3) == 0);
			end
			send_random();
		end
	endtask

	initial begin : stimulus
		s_tvalid      = 1'b0;
		s_tuser       = tccw_pkg::ACT_PUT;
		s_tdata       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = tccw_pkg::REG_NUM_COLS;
		cfg_data      = '0;
		sink_hold     = 1'b0;
		sink_eager    = 1'b0;
		src_eager     = 1'b0;
		items_sent    = 0;
		settings_used = 1;
		scr_cols      = int'(tccw_pkg::RST_NUM_COLS);
		scr_rows      = int'(tccw_pkg::RST_NUM_ROWS);
		arst_n        = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Reset screen of 80 by 25: byte extremes, wrap with scroll, backspace, tabs.
		put_char(8'h41);
		put_char(8'h00);
		put_char(8'hFF);
		put_char(tccw_pkg::CH_TAB);
		move_cursor(8'd79, 7'd24);
		put_char(8'h78);
		put_char(8'h79);
		put_char(tccw_pkg::CH_BS);
		put_char(tccw_pkg::CH_BS);
		put_char(tccw_pkg::CH_NL);
		move_cursor(8'd200, 7'd100);
		move_cursor(8'd255, 7'd127);
		move_cursor(8'd0, 7'd100);
		move_cursor(8'd76, 7'd24);
		put_char(tccw_pkg::CH_TAB);
		put_char(tccw_pkg::CH_TAB);
		send_item(tccw_pkg::ACT_NONE, 8'hA5, 8'h5A, 7'h55);
		send_item(tccw_pkg::ACT_CLEAR, 8'h00, 8'hFF, 7'h7F);
		move_cursor(8'd70, 7'd20);
		put_char(tccw_pkg::CH_NL);
		move_cursor(8'd78, 7'd22);
		drain();

		// Shrinking the screen leaves the cursor off it; the next put pulls it back.
		set_screen(8'd5, 7'd3, 32'hFFFF_FFFF, 32'h0000_0000);
		put_char(8'h63);
		drain();

		// Register values of zero give a single cell, where a tab runs into the word limit.
		set_screen(8'd0, 7'd0, 32'h0000_0000, 32'hFFFF_FFFF);
		put_char(tccw_pkg::CH_TAB);
		put_char(tccw_pkg::CH_TAB);
		send_item(tccw_pkg::ACT_CLEAR, 8'h00, 8'h00, 7'h00);
		run_random(12);
		drain();

		// Tiny screen: hold the results back while words keep coming, then pause.
		set_screen(8'd4, 7'd3, $urandom(), $urandom());
		run_random(10);
		fork
			hold_results(300);
		join_none
		src_eager = 1'b1;
		for (int i = 0; i < 20; i++)
			put_char(8'($urandom_range(32, 126)));
		drain();
		run_random(10);
		drain();

		set_screen(8'd255, 7'd127, $urandom(), $urandom());
		run_random(10);
		drain();

		set_screen(8'd1, 7'd2, $urandom(), 32'h0000_0000);
		run_random(25);
		drain();

		set_screen(8'd17, 7'd5, $urandom(), $urandom());
		run_random(30);
		drain();

		set_screen(8'd240, 7'd67, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(8);
		drain();

		set_screen(8'd9, 7'd67, $urandom(), $urandom());
		run_random(25);
		drain();

		set_screen(8'd13, 7'd1, 32'h0000_0000, 32'h0000_0000);
		run_random(20);
		drain();

		set_screen(tccw_pkg::RST_NUM_COLS, tccw_pkg::RST_NUM_ROWS, tccw_pkg::RST_FG,
		           tccw_pkg::RST_BG);
		run_random(15);
		drain();

		$display("Sent %0d input words over %0d screen settings; %0d event words checked.",
		         items_sent, settings_used, events_seen);
		$display("Covered wraps, scrolls, tab limits, cursor clamping, clears and output stalls.");
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
